@@ hw/rtl/mfps_pkg.sv @@
// Package for the Manchester frame pulse sequencer: request and pulse types,
// configuration register codes, reset values and frame constants.
// No dependencies.
`default_nettype none

package mfps_pkg;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned CfgSelW   = 3;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned DurW      = 24;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PairW     = 4;
  localparam int unsigned CntW      = 4;

  // Pulse budget of one byte and the parts of it that do not depend on the preamble
  localparam int unsigned MaxPulses   = 33;
  localparam int unsigned SyncPulses  = 2;
  localparam int unsigned DataPulses  = 16;
  localparam int unsigned WakePulses  = 2;
  localparam int unsigned SleepPulses = 1;

  localparam int unsigned FirstPreamblePairsDef  = 2;
  localparam int unsigned RepeatPreamblePairsDef = 7;

  typedef enum logic [CfgSelW-1:0] {
    REG_WAKE_HI  = 3'd0,
    REG_WAKE_LO  = 3'd1,
    REG_PRE_HI   = 3'd2,
    REG_PRE_LO   = 3'd3,
    REG_SYNC_HI  = 3'd4,
    REG_SYNC_LO  = 3'd5,
    REG_SYMBOL   = 3'd6,
    REG_SLEEP    = 3'd7
  } cfg_reg_e;

  localparam logic [DurW-1:0] CfgReset [NumRegs] = '{
    24'd9415, 24'd89565, 24'd2416, 24'd2416, 24'd4550, 24'd640, 24'd640, 24'd30415
  };

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_WAKE  = 3'd1,
    ST_PRE   = 3'd2,
    ST_SYNC  = 3'd3,
    ST_DATA  = 3'd4,
    ST_SLEEP = 3'd5
  } seq_state_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             first_byte;
    logic             last_byte;
    logic             repeated;
  } mfps_in_t;

  typedef struct packed {
    logic            level;
    logic [DurW-1:0] duration_us;
    logic            last_pulse;
  } mfps_out_t;

  typedef struct packed {
    logic               en;
    logic [CfgIdxW-1:0] idx;
    logic [DurW-1:0]    data;
  } mfps_cfg_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/mfps_cfg_regs.sv @@
// Configuration register file of the pulse sequencer: eight 24-bit duration
// registers with reset values, one write port and one read select.
// Depends on mfps_pkg.
`default_nettype none

module mfps_cfg_regs (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  mfps_pkg::mfps_cfg_wr_t       wr_i,
  input  mfps_pkg::cfg_reg_e           rd_sel_i,
  output logic [mfps_pkg::DurW-1:0]    rd_data_o
);

  logic [mfps_pkg::DurW-1:0] regs_q [mfps_pkg::NumRegs];
  logic                      wr_hit;

  // drop writes to indexes beyond the register list
  assign wr_hit = wr_i.en && (wr_i.idx < mfps_pkg::CfgIdxW'(mfps_pkg::NumRegs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= mfps_pkg::CfgReset;
    end else if (wr_hit) begin
      regs_q[wr_i.idx[mfps_pkg::CfgSelW-1:0]] <= wr_i.data;
    end
  end

  assign rd_data_o = regs_q[rd_sel_i];

endmodule

`default_nettype wire

@@ hw/rtl/manchester_frame_pulse_sequencer.sv @@
// Top level of the Manchester frame pulse sequencer: request capture, pulse
// sequencer and output register. Depends on mfps_pkg and mfps_cfg_regs.
//
// Usage: each input request carries one encoded frame byte with frame-start,
// frame-end and repeat flags. The block answers with one output request per
// pulse (level, duration from a configuration register, last-pulse flag).
// A start byte is led by wakeup (not on repeats), preamble and sync pairs;
// each data bit gives two symbol pulses, MSB first; an end byte adds a low
// sleep pulse. One byte yields 16 to 33 pulses.
// Timing: a taken request is captured into the sequencer state, from which the
// pulses enter the output register one pulse per cycle while the receiver does
// not stall. An item holds the block: in_stall_o stays high from the accept
// until the last pulse has entered the output register. The pulse sequencer
// steps one shared counter per preamble pair and per data bit and shifts the
// data register once per data bit. A stall on the output holds the output
// register and freezes the sequencer. Configuration writes are always ready
// and take effect at once; write only while idle. Reset empties the output,
// returns to idle and loads the default durations.
`default_nettype none

module manchester_frame_pulse_sequencer #(
  parameter int unsigned FIRST_PREAMBLE_PAIRS  = mfps_pkg::FirstPreamblePairsDef,
  parameter int unsigned REPEAT_PREAMBLE_PAIRS = mfps_pkg::RepeatPreamblePairsDef
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  mfps_pkg::mfps_in_t              in_req_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output mfps_pkg::mfps_out_t             out_rsp_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [mfps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [mfps_pkg::DurW-1:0]       cfg_data_i
);

  localparam int unsigned PairW = mfps_pkg::PairW;
  localparam int unsigned CntW  = mfps_pkg::CntW;
  localparam int unsigned Fixed = mfps_pkg::SyncPulses + mfps_pkg::DataPulses;

  // Preamble room left in the pulse budget, per repeat and end flags
  localparam int unsigned RoomFirst     = (mfps_pkg::MaxPulses - Fixed
                                           - mfps_pkg::WakePulses) / 2;
  localparam int unsigned RoomFirstLast = (mfps_pkg::MaxPulses - Fixed
                                           - mfps_pkg::WakePulses
                                           - mfps_pkg::SleepPulses) / 2;
  localparam int unsigned RoomRep       = (mfps_pkg::MaxPulses - Fixed) / 2;
  localparam int unsigned RoomRepLast   = (mfps_pkg::MaxPulses - Fixed
                                           - mfps_pkg::SleepPulses) / 2;

  localparam logic [PairW-1:0] PairsFirst = PairW'(
    FIRST_PREAMBLE_PAIRS < RoomFirst ? FIRST_PREAMBLE_PAIRS : RoomFirst);
  localparam logic [PairW-1:0] PairsFirstLast = PairW'(
    FIRST_PREAMBLE_PAIRS < RoomFirstLast ? FIRST_PREAMBLE_PAIRS : RoomFirstLast);
  localparam logic [PairW-1:0] PairsRep = PairW'(
    REPEAT_PREAMBLE_PAIRS < RoomRep ? REPEAT_PREAMBLE_PAIRS : RoomRep);
  localparam logic [PairW-1:0] PairsRepLast = PairW'(
    REPEAT_PREAMBLE_PAIRS < RoomRepLast ? REPEAT_PREAMBLE_PAIRS : RoomRepLast);

  localparam logic [CntW-1:0] LastDataBit = CntW'(mfps_pkg::ByteW - 1);

  mfps_pkg::seq_state_e          state_q, state_d;
  logic                          phase_q, phase_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [mfps_pkg::ByteW-1:0]    byte_q, byte_d;
  logic                          first_q, last_q, rep_q;
  logic [PairW-1:0]              pairs_q, pairs_sel;

  logic                          out_valid_q;
  mfps_pkg::mfps_out_t           out_q;

  logic                          in_take;
  logic                          advance;
  logic                          pulse_level;
  logic                          pulse_last;
  mfps_pkg::cfg_reg_e            pulse_sel;
  logic [mfps_pkg::DurW-1:0]     pulse_dur;
  mfps_pkg::mfps_cfg_wr_t        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr.en   = cfg_valid_i;
  assign cfg_wr.idx  = cfg_index_i;
  assign cfg_wr.data = cfg_data_i;

  mfps_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cfg_wr),
    .rd_sel_i  (pulse_sel),
    .rd_data_o (pulse_dur)
  );

  assign in_stall_o = (state_q != mfps_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign advance    = (state_q != mfps_pkg::ST_IDLE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (in_req_i.repeated) begin
      pairs_sel = in_req_i.last_byte ? PairsRepLast : PairsRep;
    end else begin
      pairs_sel = in_req_i.last_byte ? PairsFirstLast : PairsFirst;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    byte_d  = byte_q;
    case (state_q)
      mfps_pkg::ST_IDLE: begin
        if (in_take) begin
          phase_d = 1'b0;
          cnt_d   = '0;
          byte_d  = in_req_i.data_byte;
          if (!in_req_i.first_byte) begin
            state_d = mfps_pkg::ST_DATA;
          end else if (!in_req_i.repeated) begin
            state_d = mfps_pkg::ST_WAKE;
          end else if (pairs_sel != '0) begin
            state_d = mfps_pkg::ST_PRE;
          end else begin
            state_d = mfps_pkg::ST_SYNC;
          end
        end
      end
      mfps_pkg::ST_WAKE: begin
        if (advance) begin
          phase_d = !phase_q;
          if (phase_q) begin
            state_d = (pairs_q != '0) ? mfps_pkg::ST_PRE : mfps_pkg::ST_SYNC;
          end
        end
      end
      mfps_pkg::ST_PRE: begin
        if (advance) begin
          phase_d = !phase_q;
          if (phase_q) begin
            if (cnt_q + 1'b1 == pairs_q) begin
              cnt_d   = '0;
              state_d = mfps_pkg::ST_SYNC;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
      end
      mfps_pkg::ST_SYNC: begin
        if (advance) begin
          phase_d = !phase_q;
          if (phase_q) begin
            state_d = mfps_pkg::ST_DATA;
          end
        end
      end
      mfps_pkg::ST_DATA: begin
        if (advance) begin
          phase_d = !phase_q;
          if (phase_q) begin
            // shift the next bit up to the MSB
            byte_d = {byte_q[mfps_pkg::ByteW-2:0], 1'b0};
            if (cnt_q == LastDataBit) begin
              cnt_d   = '0;
              state_d = last_q ? mfps_pkg::ST_SLEEP : mfps_pkg::ST_IDLE;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
      end
      mfps_pkg::ST_SLEEP: begin
        if (advance) begin
          state_d = mfps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mfps_pkg::ST_IDLE;
      end
    endcase
  end

  // Pulse of the current step
  always_comb begin
    pulse_level = 1'b0;
    pulse_sel   = mfps_pkg::REG_SYMBOL;
    pulse_last  = 1'b0;
    case (state_q)
      mfps_pkg::ST_WAKE: begin
        pulse_level = !phase_q;
        pulse_sel   = phase_q ? mfps_pkg::REG_WAKE_LO : mfps_pkg::REG_WAKE_HI;
      end
      mfps_pkg::ST_PRE: begin
        pulse_level = !phase_q;
        pulse_sel   = phase_q ? mfps_pkg::REG_PRE_LO : mfps_pkg::REG_PRE_HI;
      end
      mfps_pkg::ST_SYNC: begin
        pulse_level = !phase_q;
        pulse_sel   = phase_q ? mfps_pkg::REG_SYNC_LO : mfps_pkg::REG_SYNC_HI;
      end
      mfps_pkg::ST_DATA: begin
        // low-high for a one, high-low for a zero
        pulse_level = phase_q ? byte_q[mfps_pkg::ByteW-1] : !byte_q[mfps_pkg::ByteW-1];
        pulse_sel   = mfps_pkg::REG_SYMBOL;
        pulse_last  = phase_q && (cnt_q == LastDataBit) && !last_q;
      end
      mfps_pkg::ST_SLEEP: begin
        pulse_level = 1'b0;
        pulse_sel   = mfps_pkg::REG_SLEEP;
        pulse_last  = 1'b1;
      end
      default: begin
        pulse_level = 1'b0;
        pulse_sel   = mfps_pkg::REG_SYMBOL;
        pulse_last  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfps_pkg::ST_IDLE;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (in_take) begin
      first_q <= in_req_i.first_byte;
      last_q  <= in_req_i.last_byte;
      rep_q   <= in_req_i.repeated;
      pairs_q <= pairs_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.level       <= pulse_level;
      out_q.duration_us <= pulse_dur;
      out_q.last_pulse  <= pulse_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_sleep_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfps_pkg::ST_SLEEP) |-> last_q)
    else $error("sleep pulse on a byte that does not end a frame");

  a_wake_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfps_pkg::ST_WAKE) |-> (first_q && !rep_q))
    else $error("wakeup pulse outside a first-send frame start");

  a_pre_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfps_pkg::ST_PRE) |-> (first_q && (cnt_q < pairs_q)))
    else $error("preamble pair count out of range");

  a_data_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfps_pkg::ST_DATA) |-> (cnt_q <= LastDataBit))
    else $error("data bit count out of range");

endmodule

`default_nettype wire

@@ test/tb_manchester_frame_pulse_sequencer.sv @@
// Testbench for manchester_frame_pulse_sequencer: drives frame bytes and register writes,
// predicts every pulse and checks each one as it leaves the block.
// Depends on mfps_pkg and the RTL of the block.
`default_nettype none

module tb_manchester_frame_pulse_sequencer;
  import mfps_pkg::*;

  localparam int unsigned FirstPairs   = FirstPreamblePairsDef;
  localparam int unsigned RepeatPairs  = RepeatPreamblePairsDef;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned SettleCycles = MaxPulses + 8;
  localparam int unsigned ItemsPerSetting = 15;
  localparam logic [CfgIdxW-1:0] UnusedIdxLow  = CfgIdxW'(NumRegs);
  localparam logic [CfgIdxW-1:0] UnusedIdxHigh = '1;
  localparam logic [DurW-1:0]    DurMax        = '1;

  typedef enum logic [1:0] {
    ROW_BYTE    = 2'd0,
    ROW_SET_ALL = 2'd1,
    ROW_SET_ONE = 2'd2
  } row_kind_e;

  // typed: first pulse level and duration given in the row
  typedef struct packed {
    row_kind_e          kind;
    mfps_in_t           req;
    logic [CfgIdxW-1:0] idx;
    logic               typed;
    logic               lvl;
    logic [DurW-1:0]    dur;
  } row_t;

  localparam int NumRows = 21;
  // req fields: data_byte, first_byte, last_byte, repeated
  localparam row_t DirectedRows [NumRows] = '{
    '{ROW_BYTE,    '{8'h00, 1'b0, 1'b0, 1'b0}, '0, 1'b1, 1'b1, 24'd640},
    '{ROW_BYTE,    '{8'hFF, 1'b0, 1'b0, 1'b0}, '0, 1'b1, 1'b0, 24'd640},
    '{ROW_BYTE,    '{8'hA5, 1'b1, 1'b0, 1'b0}, '0, 1'b1, 1'b1, 24'd9415},
    '{ROW_BYTE,    '{8'h5A, 1'b1, 1'b0, 1'b1}, '0, 1'b1, 1'b1, 24'd2416},
    '{ROW_BYTE,    '{8'h3C, 1'b0, 1'b0, 1'b1}, '0, 1'b1, 1'b1, 24'd640},
    '{ROW_BYTE,    '{8'h81, 1'b0, 1'b1, 1'b0}, '0, 1'b1, 1'b0, 24'd640},
    '{ROW_BYTE,    '{8'h00, 1'b1, 1'b1, 1'b0}, '0, 1'b1, 1'b1, 24'd9415},
    '{ROW_BYTE,    '{8'hFF, 1'b1, 1'b1, 1'b1}, '0, 1'b1, 1'b1, 24'd2416},
    '{ROW_SET_ALL, '0,                         '0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,    '{8'h00, 1'b1, 1'b1, 1'b0}, '0, 1'b1, 1'b1, 24'd0},
    '{ROW_BYTE,    '{8'hC3, 1'b0, 1'b1, 1'b0}, '0, 1'b1, 1'b0, 24'd0},
    '{ROW_SET_ALL, '0,                         '0, 1'b0, 1'b0, DurMax},
    '{ROW_BYTE,    '{8'hFF, 1'b1, 1'b1, 1'b1}, '0, 1'b1, 1'b1, DurMax},
    '{ROW_BYTE,    '{8'h7E, 1'b1, 1'b0, 1'b0}, '0, 1'b1, 1'b1, DurMax},
    '{ROW_SET_ONE, '0, UnusedIdxLow,              1'b0, 1'b0, 24'd0},
    '{ROW_SET_ONE, '0, UnusedIdxHigh,             1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,    '{8'h96, 1'b0, 1'b0, 1'b0}, '0, 1'b1, 1'b0, DurMax},
    '{ROW_SET_ONE, '0, CfgIdxW'(REG_SYMBOL),      1'b0, 1'b0, 24'h000001},
    '{ROW_SET_ONE, '0, CfgIdxW'(REG_SLEEP),       1'b0, 1'b0, 24'h800000},
    '{ROW_BYTE,    '{8'h55, 1'b1, 1'b1, 1'b0}, '0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,    '{8'hAA, 1'b0, 1'b1, 1'b0}, '0, 1'b0, 1'b0, 24'd0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  mfps_in_t           in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  mfps_out_t          out_rsp_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DurW-1:0]    cfg_data_i;

  logic [DurW-1:0] dur_regs [NumRegs];
  mfps_out_t       due_pulses [$];
  int errors = 0;
  int items_sent = 0;
  int pulses_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  manchester_frame_pulse_sequencer #(
    .FIRST_PREAMBLE_PAIRS (FirstPairs),
    .REPEAT_PREAMBLE_PAIRS(RepeatPairs)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [DurW-1:0] got,
                                 input logic [DurW-1:0] want);
    errors++;
    if (errors <= 20) begin
      $display("MISMATCH at pulse %0d: %s, got 0x%0h, expected 0x%0h",
               pulses_seen, what, got, want);
    end
  endtask

  function automatic void add_pulse(logic lvl, cfg_reg_e r);
    due_pulses.push_back('{level: lvl, duration_us: dur_regs[r], last_pulse: 1'b0});
  endfunction

  // Append the pulses that one frame byte produces.
  function automatic void expand_byte(mfps_in_t req);
    int unsigned pairs;
    int unsigned fixed;
    int unsigned room;
    if (req.first_byte) begin
      pairs = req.repeated ? RepeatPairs : FirstPairs;
      fixed = SyncPulses + DataPulses + (req.repeated ? 0 : WakePulses)
            + (req.last_byte ? SleepPulses : 0);
      room = (MaxPulses - fixed) / 2;
      // cap the preamble so one byte never exceeds the pulse budget
      if (pairs > room) pairs = room;
      if (!req.repeated) begin
        add_pulse(1'b1, REG_WAKE_HI);
        add_pulse(1'b0, REG_WAKE_LO);
      end
      for (int unsigned p = 0; p < pairs; p++) begin
        add_pulse(1'b1, REG_PRE_HI);
        add_pulse(1'b0, REG_PRE_LO);
      end
      add_pulse(1'b1, REG_SYNC_HI);
      add_pulse(1'b0, REG_SYNC_LO);
    end
    for (int b = ByteW - 1; b >= 0; b--) begin
      add_pulse(~req.data_byte[b], REG_SYMBOL);
      add_pulse(req.data_byte[b], REG_SYMBOL);
    end
    if (req.last_byte) add_pulse(1'b0, REG_SLEEP);
    due_pulses[due_pulses.size() - 1].last_pulse = 1'b1;
  endfunction

  // Called right after a rising edge; returns at the edge that takes the request.
  task automatic push_request(input mfps_in_t req, input logic typed, input logic lvl,
                              input logic [DurW-1:0] dur);
    int base;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    base = due_pulses.size();
    expand_byte(req);
    if (typed) begin
      due_pulses[base].level       = lvl;
      due_pulses[base].duration_us = dur;
    end
    items_sent++;
  endtask

  // Hold the sender until every predicted pulse has been seen.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_pulses.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NumRegs) dur_regs[idx[CfgSelW-1:0]] = val;
    cfg_writes++;
  endtask

  task automatic random_setting();
    logic [DurW-1:0] val;
    settle();
    for (int r = 0; r < NumRegs; r++) begin
      case ($urandom_range(3))
        0: val = '0;
        1: val = DurMax;
        default: val = DurW'($urandom);
      endcase
      write_reg(CfgIdxW'(r), val);
    end
    if ($urandom_range(1) == 1) begin
      write_reg(UnusedIdxLow + CfgIdxW'($urandom_range(NumRegs - 1)), DurW'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed frames of one to four bytes, some stray bytes.
  task automatic send_frame();
    mfps_in_t req;
    int       len;
    logic     rep;
    if ($urandom_range(9) == 0) begin
      req.data_byte  = ByteW'($urandom_range(255));
      req.first_byte = 1'($urandom_range(1));
      req.last_byte  = 1'($urandom_range(1));
      req.repeated   = 1'($urandom_range(1));
      push_request(req, 1'b0, 1'b0, '0);
    end else begin
      len = $urandom_range(1, 4);
      rep = 1'($urandom_range(1));
      for (int k = 0; k < len; k++) begin
        req.data_byte  = ByteW'($urandom_range(255));
        req.first_byte = (k == 0);
        req.last_byte  = (k == len - 1);
        // the repeat flag matters only on a start byte
        req.repeated   = (k == 0) ? rep : 1'($urandom_range(1));
        push_request(req, 1'b0, 1'b0, '0);
      end
    end
    if ($urandom_range(14) == 0) settle();
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk_i) begin : pulse_check
    mfps_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_pulses.size() == 0) begin
        report_mismatch("pulse with none expected", out_rsp_o.duration_us, '0);
      end else begin
        want = due_pulses.pop_front();
        if (out_rsp_o.level !== want.level)
          report_mismatch("level", out_rsp_o.level, want.level);
        if (out_rsp_o.duration_us !== want.duration_us)
          report_mismatch("duration_us", out_rsp_o.duration_us, want.duration_us);
        if (out_rsp_o.last_pulse !== want.last_pulse)
          report_mismatch("last_pulse", out_rsp_o.last_pulse, want.last_pulse);
      end
      pulses_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("Timeout: no request moved for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    row_t row;
    int   target;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    for (int r = 0; r < NumRegs; r++) dur_regs[r] = CfgReset[r];
    sender_idle_pct   = 13;
    receiver_idle_pct = 67;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      row = DirectedRows[i];
      case (row.kind)
        ROW_BYTE: begin
          push_request(row.req, row.typed, row.lvl, row.dur);
        end
        ROW_SET_ALL: begin
          settle();
          for (int r = 0; r < NumRegs; r++) write_reg(CfgIdxW'(r), row.dur);
          cfg_valid_i <= 1'b0;
        end
        default: begin
          settle();
          write_reg(row.idx, row.dur);
          cfg_valid_i <= 1'b0;
        end
      endcase
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          sender_idle_pct   = 13;
          receiver_idle_pct = 67;
        end
        1: begin
          sender_idle_pct   = 67;
          receiver_idle_pct = 13;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      repeat (2) begin
        random_setting();
        target = items_sent + ItemsPerSetting;
        while (items_sent < target) send_frame();
      end
    end

    in_valid_i <= 1'b0;
    while (due_pulses.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (due_pulses.size() != 0) begin
      report_mismatch("pulses never produced", DurW'(due_pulses.size()), '0);
    end

    $display("Run covered %0d frame bytes (header, repeat, data and sleep cases) giving %0d pulses,",
             items_sent, pulses_seen);
    $display("%0d register writes incl. zero, full-scale and unused indexes, idle 13/67, 67/13, 0/0.",
             cfg_writes);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/mfps_pkg.sv
hw/rtl/mfps_cfg_regs.sv
hw/rtl/manchester_frame_pulse_sequencer.sv
test/tb_manchester_frame_pulse_sequencer.sv
